// File: sv/q2rm_pkg.sv
// q2rm_pkg: types and constants of the quaternion to rotation matrix block
// no dependencies; used by quaternion_to_rotation_matrix and its checker
package q2rm_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int FRACTION_BITS  = 14;
    localparam int OUT_W          = 16;
    // product of two components
    localparam int PROD_W    = 2 * COMPONENT_BITS;
    // squared norm, numerators and remainders
    localparam int NORM_W    = 2 * COMPONENT_BITS + 1;
    // quotient bits: one integer bit, FRACTION_BITS + 1, one rounding bit
    localparam int QUO_W     = FRACTION_BITS + 3;
    localparam int DIV_STEPS = QUO_W;
    localparam int LANES     = 9;
    localparam int ENTRY_W   = QUO_W + 2;

    localparam logic signed [ENTRY_W-1:0] ONE = ENTRY_W'(1) <<< FRACTION_BITS;
    localparam logic signed [OUT_W-1:0] ONE_OUT = OUT_W'(ONE);

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] quat_w;
        logic signed [COMPONENT_BITS-1:0] quat_x;
        logic signed [COMPONENT_BITS-1:0] quat_y;
        logic signed [COMPONENT_BITS-1:0] quat_z;
    } quat_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] m00;
        logic signed [OUT_W-1:0] m01;
        logic signed [OUT_W-1:0] m02;
        logic signed [OUT_W-1:0] m10;
        logic signed [OUT_W-1:0] m11;
        logic signed [OUT_W-1:0] m12;
        logic signed [OUT_W-1:0] m20;
        logic signed [OUT_W-1:0] m21;
        logic signed [OUT_W-1:0] m22;
        logic                    zero_norm;
    } rot_out_t;

endpackage

// File: sv/quaternion_to_rotation_matrix.sv
// quaternion_to_rotation_matrix: raw quaternion in, Q1.14 rotation matrix out
// depends on q2rm_pkg
//
// Usage:
//   s_valid/s_ready/s_data carry one quaternion item (w, x, y, z, signed).
//   m_valid/m_ready/m_data carry the nine matrix entries and zero_norm.
//   Entries are 2*p/n (off-diagonal) and 1 - 2*s/n (diagonal) with n the
//   squared norm, rounded half away from zero, saturated to +-1.0.
// Pipeline from accept to m_valid: products, sums, 17 restoring
//   division steps, one per stage for all nine entries in parallel, output.
// Throughput: one item per cycle unless stalled; all stages advance together.
// Stall: while m_valid is high and m_ready low, every stage holds and
//   s_ready is low; nothing is dropped or repeated. s_ready follows
//   m_ready combinationally when the output register is full.
// Reset: aresetn (synchronous, active low) clears all valid bits; no
//   item is in flight afterwards. Payload registers are not reset.
// A zero quaternion gives the identity matrix with zero_norm set.
module quaternion_to_rotation_matrix (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  q2rm_pkg::quat_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output q2rm_pkg::rot_out_t  m_data
);
    import q2rm_pkg::*;

    logic adv;

    // stage 1: products
    logic                     p1_vld_reg;
    logic signed [PROD_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0] xy_reg, zw_reg, xz_reg, yw_reg, yz_reg, xw_reg;

    // stage 2: norm and numerators
    logic                  p2_vld_reg;
    logic [NORM_W-1:0]     den0_reg;
    logic [NORM_W-1:0]     num_reg [LANES];
    logic [LANES-1:0]      neg0_reg;
    logic                  zero0_reg;
    logic [NORM_W-1:0]     num_next [LANES];
    logic [LANES-1:0]      neg0_next;
    logic [NORM_W-1:0]     den0_next;

    // division stages, index k+1 holds the result of step k
    logic [DIV_STEPS:1]    dv_vld_reg;
    logic [NORM_W-1:0]     rem_reg [1:DIV_STEPS][LANES];
    logic [QUO_W-1:0]      quo_reg [1:DIV_STEPS][LANES];
    logic [NORM_W-1:0]     den_reg [1:DIV_STEPS];
    logic [LANES-1:0]      neg_reg [1:DIV_STEPS];
    logic [DIV_STEPS:1]    zero_reg;

    // output
    logic      m_valid_reg;
    rot_out_t  m_data_reg;
    rot_out_t  m_data_next;

    assign adv     = m_ready || !m_valid_reg;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // stage 1 and stage 2 valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end else if (adv) begin
            p1_vld_reg <= s_valid;
            p2_vld_reg <= p1_vld_reg;
        end
    end

    // stage 1 products
    always_ff @(posedge aclk) begin
        if (adv) begin
            ww_reg <= s_data.quat_w * s_data.quat_w;
            xx_reg <= s_data.quat_x * s_data.quat_x;
            yy_reg <= s_data.quat_y * s_data.quat_y;
            zz_reg <= s_data.quat_z * s_data.quat_z;
            xy_reg <= s_data.quat_x * s_data.quat_y;
            zw_reg <= s_data.quat_z * s_data.quat_w;
            xz_reg <= s_data.quat_x * s_data.quat_z;
            yw_reg <= s_data.quat_y * s_data.quat_w;
            yz_reg <= s_data.quat_y * s_data.quat_z;
            xw_reg <= s_data.quat_x * s_data.quat_w;
        end
    end

    // stage 2 sums, magnitudes and signs
    always_comb begin
        logic [NORM_W-1:0]        ww_u, xx_u, yy_u, zz_u;
        logic signed [NORM_W-1:0] p [6];
        ww_u = {1'b0, ww_reg};
        xx_u = {1'b0, xx_reg};
        yy_u = {1'b0, yy_reg};
        zz_u = {1'b0, zz_reg};
        den0_next = ww_u + xx_u + yy_u + zz_u;
        p[0] = NORM_W'(xy_reg) - NORM_W'(zw_reg);
        p[1] = NORM_W'(xz_reg) + NORM_W'(yw_reg);
        p[2] = NORM_W'(xy_reg) + NORM_W'(zw_reg);
        p[3] = NORM_W'(yz_reg) - NORM_W'(xw_reg);
        p[4] = NORM_W'(xz_reg) - NORM_W'(yw_reg);
        p[5] = NORM_W'(yz_reg) + NORM_W'(xw_reg);
        num_next[0] = yy_u + zz_u;
        num_next[4] = xx_u + zz_u;
        num_next[8] = xx_u + yy_u;
        neg0_next   = '0;
        num_next[1] = p[0][NORM_W-1] ? NORM_W'(-p[0]) : NORM_W'(p[0]);
        num_next[2] = p[1][NORM_W-1] ? NORM_W'(-p[1]) : NORM_W'(p[1]);
        num_next[3] = p[2][NORM_W-1] ? NORM_W'(-p[2]) : NORM_W'(p[2]);
        num_next[5] = p[3][NORM_W-1] ? NORM_W'(-p[3]) : NORM_W'(p[3]);
        num_next[6] = p[4][NORM_W-1] ? NORM_W'(-p[4]) : NORM_W'(p[4]);
        num_next[7] = p[5][NORM_W-1] ? NORM_W'(-p[5]) : NORM_W'(p[5]);
        neg0_next[1] = p[0][NORM_W-1];
        neg0_next[2] = p[1][NORM_W-1];
        neg0_next[3] = p[2][NORM_W-1];
        neg0_next[5] = p[3][NORM_W-1];
        neg0_next[6] = p[4][NORM_W-1];
        neg0_next[7] = p[5][NORM_W-1];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            den0_reg  <= den0_next;
            num_reg   <= num_next;
            neg0_reg  <= neg0_next;
            zero0_reg <= (den0_next == '0);
        end
    end

    // restoring division, one quotient bit per stage for all lanes
    genvar k, ln;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_step
            logic                  vld_in;
            logic [NORM_W-1:0]     den_in;
            logic [LANES-1:0]      neg_in;
            logic                  zero_in;
            logic [NORM_W-1:0]     rem_in [LANES];
            logic [QUO_W-1:0]      quo_in [LANES];
            logic [NORM_W-1:0]     rem_next [LANES];
            logic [QUO_W-1:0]      quo_next [LANES];

            if (k == 0) begin : g_first
                assign vld_in  = p2_vld_reg;
                assign den_in  = den0_reg;
                assign neg_in  = neg0_reg;
                assign zero_in = zero0_reg;
                for (ln = 0; ln < LANES; ln++) begin : g_ln
                    assign rem_in[ln] = num_reg[ln];
                    assign quo_in[ln] = '0;
                end
            end else begin : g_rest
                assign vld_in  = dv_vld_reg[k];
                assign den_in  = den_reg[k];
                assign neg_in  = neg_reg[k];
                assign zero_in = zero_reg[k];
                for (ln = 0; ln < LANES; ln++) begin : g_ln
                    assign rem_in[ln] = rem_reg[k][ln];
                    assign quo_in[ln] = quo_reg[k][ln];
                end
            end

            // first step compares the numerator unshifted
            for (ln = 0; ln < LANES; ln++) begin : g_lane
                logic [NORM_W:0] trial;
                logic            ge;
                assign trial = (k == 0) ? {1'b0, rem_in[ln]} : {rem_in[ln], 1'b0};
                assign ge    = (trial >= {1'b0, den_in});
                assign rem_next[ln] = ge ? NORM_W'(trial - {1'b0, den_in})
                                         : NORM_W'(trial);
                assign quo_next[ln] = {quo_in[ln][QUO_W-2:0], ge};
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    dv_vld_reg[k+1] <= 1'b0;
                end else if (adv) begin
                    dv_vld_reg[k+1] <= vld_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    den_reg[k+1]  <= den_in;
                    neg_reg[k+1]  <= neg_in;
                    zero_reg[k+1] <= zero_in;
                    rem_reg[k+1]  <= rem_next;
                    quo_reg[k+1]  <= quo_next;
                end
            end
        end
    endgenerate

    // rounding, sign, saturation and the zero-norm identity
    always_comb begin
        logic signed [ENTRY_W-1:0] e [LANES];
        logic signed [ENTRY_W-1:0] r;
        logic [OUT_W-1:0]          o [LANES];
        for (int i = 0; i < LANES; i++) begin
            r = signed'(ENTRY_W'((ENTRY_W'(quo_reg[DIV_STEPS][i]) + ENTRY_W'(1)) >> 1));
            if (i == 0 || i == 4 || i == 8) begin
                e[i] = ONE - r;
            end else begin
                e[i] = neg_reg[DIV_STEPS][i] ? -r : r;
            end
            if (e[i] > ONE) begin
                e[i] = ONE;
            end else if (e[i] < -ONE) begin
                e[i] = -ONE;
            end
            if (zero_reg[DIV_STEPS]) begin
                e[i] = (i == 0 || i == 4 || i == 8) ? ONE : '0;
            end
            o[i] = e[i][OUT_W-1:0];
        end
        m_data_next.m00       = o[0];
        m_data_next.m01       = o[1];
        m_data_next.m02       = o[2];
        m_data_next.m10       = o[3];
        m_data_next.m11       = o[4];
        m_data_next.m12       = o[5];
        m_data_next.m20       = o[6];
        m_data_next.m21       = o[7];
        m_data_next.m22       = o[8];
        m_data_next.zero_norm = zero_reg[DIV_STEPS];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// File: sv/q2rm_checker.sv
// q2rm_checker: port-level assertions for quaternion_to_rotation_matrix
// depends on q2rm_pkg; bound to the top level at the end of this file
module q2rm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input q2rm_pkg::quat_in_t s_data,
    input logic               m_valid,
    input logic               m_ready,
    input q2rm_pkg::rot_out_t m_data
);
    import q2rm_pkg::*;

    // a stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // an empty output side never blocks the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // zero quaternion gives ones on the diagonal and zero in m01, m12 and m20
    a_ident: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_norm |->
            m_data.m00 == ONE_OUT && m_data.m11 == ONE_OUT && m_data.m22 == ONE_OUT
            && m_data.m01 == '0 && m_data.m12 == '0 && m_data.m20 == '0)
        else $error("zero norm without identity");

    // entries m00 and m01 stay within one
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.m00 <= ONE_OUT && m_data.m00 >= -ONE_OUT
            && m_data.m01 <= ONE_OUT && m_data.m01 >= -ONE_OUT)
        else $error("entry out of range");

endmodule

bind quaternion_to_rotation_matrix q2rm_checker u_q2rm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: tb/sv/quaternion_to_rotation_matrix_test.sv
// quaternion_to_rotation_matrix_test: self-checking bench for the quaternion to matrix block
// depends on q2rm_pkg and quaternion_to_rotation_matrix; computes expected matrices itself
module quaternion_to_rotation_matrix_test;
    import q2rm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 80;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    quat_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rot_out_t m_data;

    rot_out_t pending_matrices[$];
    int mismatch_count = 0;
    int items_sent = 0;
    int matrices_seen = 0;
    int zero_quats = 0;
    int idle_cycles = 0;
    bit send_bursty = 1'b0;
    bit hold_off_req = 1'b0;
    bit hold_off_active = 1'b0;

    quaternion_to_rotation_matrix dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // round(2^(FRACTION_BITS+1) * a / n), half up, for 0 <= a <= n
    function automatic longint scaled_ratio(longint a, longint n);
        longint q;
        q = (a << (FRACTION_BITS + 2)) / n;
        return (q + 1) >>> 1;
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp_unit(longint v);
        longint one;
        one = longint'(1) << FRACTION_BITS;
        if (v > one) v = one;
        if (v < -one) v = -one;
        return v[OUT_W-1:0];
    endfunction

    function automatic logic signed [OUT_W-1:0] off_entry(longint p, longint n);
        longint q;
        q = scaled_ratio(p < 0 ? -p : p, n);
        return clamp_unit(p < 0 ? -q : q);
    endfunction

    function automatic logic signed [OUT_W-1:0] diag_entry(longint s, longint n);
        return clamp_unit((longint'(1) << FRACTION_BITS) - scaled_ratio(s, n));
    endfunction

    // expected rotation matrix of one raw quaternion
    function automatic rot_out_t rotation_of(quat_in_t q);
        rot_out_t m;
        longint w, x, y, z, ww, xx, yy, zz, n;
        w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
        ww = w * w; xx = x * x; yy = y * y; zz = z * z;
        n = ww + xx + yy + zz;
        m = '0;
        if (n == 0) begin
            m.m00 = ONE_OUT; m.m11 = ONE_OUT; m.m22 = ONE_OUT;
            m.zero_norm = 1'b1;
        end else begin
            m.m00 = diag_entry(yy + zz, n);
            m.m01 = off_entry(x * y - z * w, n);
            m.m02 = off_entry(x * z + y * w, n);
            m.m10 = off_entry(x * y + z * w, n);
            m.m11 = diag_entry(xx + zz, n);
            m.m12 = off_entry(y * z - x * w, n);
            m.m20 = off_entry(x * z - y * w, n);
            m.m21 = off_entry(y * z + x * w, n);
            m.m22 = diag_entry(xx + yy, n);
        end
        return m;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        $display("error: result %0d field %s got %0d expected %0d",
                 matrices_seen, what, got, want);
    endtask

    // offer one item, honoring burst gaps, and wait for acceptance
    task automatic send_quat(quat_in_t q);
        if (send_bursty && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= q;
        do @(posedge aclk); while (!s_ready);
        pending_matrices.insert(pending_matrices.size(), rotation_of(q));
        items_sent++;
        if (q == '0) zero_quats++;
    endtask

    task automatic send_components(int w, int x, int y, int z);
        quat_in_t q;
        q.quat_w = 16'(w); q.quat_x = 16'(x); q.quat_y = 16'(y); q.quat_z = 16'(z);
        send_quat(q);
    endtask

    // drop valid and wait until every expected result has come
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_matrices.size() != 0);
    endtask

    // compare each accepted result with the oldest expected matrix
    always @(posedge aclk) begin
        rot_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_matrices.size() == 0) begin
                mismatch_count++;
                $display("error: result with nothing expected");
            end else begin
                want = pending_matrices.pop_front();
                if (m_data.m00 !== want.m00) report_mismatch("m00", m_data.m00, want.m00);
                if (m_data.m01 !== want.m01) report_mismatch("m01", m_data.m01, want.m01);
                if (m_data.m02 !== want.m02) report_mismatch("m02", m_data.m02, want.m02);
                if (m_data.m10 !== want.m10) report_mismatch("m10", m_data.m10, want.m10);
                if (m_data.m11 !== want.m11) report_mismatch("m11", m_data.m11, want.m11);
                if (m_data.m12 !== want.m12) report_mismatch("m12", m_data.m12, want.m12);
                if (m_data.m20 !== want.m20) report_mismatch("m20", m_data.m20, want.m20);
                if (m_data.m21 !== want.m21) report_mismatch("m21", m_data.m21, want.m21);
                if (m_data.m22 !== want.m22) report_mismatch("m22", m_data.m22, want.m22);
                if (m_data.zero_norm !== want.zero_norm)
                    report_mismatch("zero_norm", m_data.zero_norm, want.zero_norm);
            end
            matrices_seen++;
        end
    end

    // receiver stall pattern, with one long hold-off on request
    always @(posedge aclk) begin
        int stall_left;
        if (hold_off_req && !hold_off_active) begin
            hold_off_active <= 1'b1;
            m_ready <= 1'b0;
            stall_left = HOLD_OFF_CYCLES;
        end else if (hold_off_active) begin
            stall_left = stall_left - 1;
            if (stall_left == 0) hold_off_active <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0) || (($urandom & 63) > 40);
        end
    end

    // watchdog on cycles with no acceptance
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("quaternion_to_rotation_matrix: mismatch");
            $finish;
        end
    end

    task automatic test_extremes();
        send_components(0, 0, 0, 0);
        send_components(1, 0, 0, 0);
        send_components(-1, 0, 0, 0);
        send_components(0, 1, 0, 0);
        send_components(0, 0, -1, 0);
        send_components(0, 0, 0, 32767);
        send_components(-32768, 0, 0, 0);
        send_components(-32768, -32768, -32768, -32768);
        send_components(32767, 32767, 32767, 32767);
        send_components(32767, -32768, 32767, -32768);
        send_components(1, 1, 1, 1);
        send_components(1, 1, 0, 0);
        send_components(0, 1, 1, 0);
        send_components(0, 0, 1, 1);
        send_components(3, 0, 0, 1);
        send_components(1, 2, 3, 4);
        send_components(-7, 5, -3, 1);
        send_components(16384, 0, 0, 0);
        send_components(0, 0, 0, 0);
        wait_drained();
    endtask

    function automatic quat_in_t random_quat();
        quat_in_t q;
        case ($urandom_range(0, 3))
            0: q = {$urandom, $urandom};
            1: begin
                q.quat_w = 16'($urandom_range(0, 15)) - 16'd8;
                q.quat_x = 16'($urandom_range(0, 15)) - 16'd8;
                q.quat_y = 16'($urandom_range(0, 15)) - 16'd8;
                q.quat_z = 16'($urandom_range(0, 15)) - 16'd8;
            end
            2: begin
                q = {$urandom, $urandom};
                q.quat_x = q.quat_x >>> $urandom_range(0, 15);
                q.quat_y = q.quat_y >>> $urandom_range(0, 15);
            end
            default: begin
                q = '0;
                q.quat_w = 16'($urandom);
                if ($urandom_range(0, 1)) q.quat_z = 16'($urandom);
            end
        endcase
        return q;
    endfunction

    task automatic test_random_stream(int count);
        send_bursty = 1'b1;
        repeat (count) send_quat(random_quat());
        send_bursty = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_off_req <= 1'b1;
        @(posedge aclk);
        hold_off_req <= 1'b0;
        repeat (60) send_quat(random_quat());
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_random_stream(600);
        wait_drained();
        test_backpressure();
        test_random_stream(620);
        wait_drained();
        repeat (40) @(posedge aclk);
        $display("sent %0d quaternions (%0d zero), checked %0d matrices",
                 items_sent, zero_quats, matrices_seen);
        $display("covered extremes, random scales, long output stall and bursty input");
        if (mismatch_count == 0 && pending_matrices.size() == 0)
            $display("quaternion_to_rotation_matrix: match");
        else
            $display("quaternion_to_rotation_matrix: mismatch");
        $finish;
    end
endmodule
